>>> hdl/dtpc_pkg.sv
// Shared types and defaults for the digit trie prefix checker.
// Used by dtpc_store and digit_trie_prefix_checker; depends on nothing.
package dtpc_pkg;

	localparam int NODES_DEF = 4096;
	localparam int RADIX_DEF = 10;
	localparam int DIGIT_W   = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MARK,
		ST_CLEAR
	} state_t;

	// enables from the sequencer to the node store
	typedef struct packed {
		logic rd;       // read child row of a node
		logic alloc;    // write a new link into the row last read
		logic mark_rd;  // read end mark of a node
		logic mark_wr;  // set end mark of a node
		logic clear;    // start a clearing sweep
	} store_ctl_t;

endpackage

>>> hdl/dtpc_store.sv
// Node store: child link rows and end marks, with the clearing sweep.
// Depends on dtpc_pkg.
module dtpc_store import dtpc_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int RADIX = RADIX_DEF,
	localparam int NW = $clog2(NODES),
	localparam int DW = $clog2(RADIX)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  store_ctl_t         ctl,
	input  logic [NW-1:0]      rd_node,
	input  logic [DIGIT_W-1:0] digit,
	input  logic [NW-1:0]      alloc_link,
	input  logic [NW-1:0]      mark_rd_node,
	input  logic [NW-1:0]      mark_wr_node,
	output logic [NW-1:0]      link,
	output logic               mark,
	output logic               clearing
);

	typedef logic [RADIX-1:0][NW-1:0] row_t;

	row_t          child_mem [NODES];
	logic          end_mem   [NODES];

	row_t          row_s1;
	row_t          row_wr;
	logic [NW-1:0] rd_node_s1;
	logic          mark_s1;
	logic [NW-1:0] clr_idx_q;
	logic          clearing_q;
	logic [DW-1:0] slot;

	assign slot = digit[DW-1:0];
	assign link = row_s1[slot];
	assign mark = mark_s1;
	assign clearing = clearing_q;

	always_comb begin
		row_wr = row_s1;
		row_wr[slot] = alloc_link;
	end

	// sweep one row a cycle; start from reset and on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (ctl.clear) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == NW'(NODES - 1)) begin
				clearing_q <= 1'b0;
				clr_idx_q  <= '0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			child_mem[clr_idx_q] <= '0;
			end_mem[clr_idx_q]   <= 1'b0;
		end else begin
			if (ctl.alloc) begin
				child_mem[rd_node_s1] <= row_wr;
			end
			if (ctl.mark_wr) begin
				end_mem[mark_wr_node] <= 1'b1;
			end
		end
		if (ctl.rd) begin
			row_s1     <= child_mem[rd_node];
			rd_node_s1 <= rd_node;
		end
		if (ctl.mark_rd) begin
			mark_s1 <= end_mem[mark_rd_node];
		end
	end

endmodule

>>> hdl/digit_trie_prefix_checker.sv
// Top level of the digit trie prefix checker: sequencer, flags and ports.
// Depends on dtpc_pkg and dtpc_store.
//
// Strings of digits arrive one beat per digit and are threaded into a trie
// of NODES nodes, each holding RADIX child links in one row of a synchronous
// memory; a separate one-bit memory keeps the end-of-string marks. A beat is
// taken when start is high and busy is low. A digit beat first reads the
// child row of the current node; when it allocates a node, meets a full pool
// or carries a digit of RADIX or more it ends there, and when it follows an
// existing link it goes on to read the end mark of the child reached. A
// new-set beat (action high) starts a sweep that zeroes one row of both
// memories a cycle, with busy high until the sweep is through; the same
// sweep runs after reset before the first beat is taken. On the last digit
// of a string, done pulses for exactly one cycle with consistent and overflow
// valid; the receiver cannot stall it, so capture the result in that cycle.
// Digit beats that are not last and new-set beats give no result.
module digit_trie_prefix_checker import dtpc_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int RADIX = RADIX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [DIGIT_W-1:0] digit,
	input  logic               last,
	output logic               done,
	output logic               consistent,
	output logic               overflow
);

	localparam int NW = $clog2(NODES);
	localparam int FW = NW + 1;

	state_t             state_q, state_d;
	logic [NW-1:0]      cur_q, cur_d;
	logic [FW-1:0]      free_q, free_d;
	logic               path_q, path_d;
	logic               cons_q, cons_d;
	logic               ovf_q, ovf_d;
	logic               done_q, done_d;
	logic [DIGIT_W-1:0] digit_s1;
	logic               last_s1;

	store_ctl_t         ctl;
	logic [NW-1:0]      link;
	logic               mark;
	logic               clearing;
	logic [NW-1:0]      mark_rd_node;
	logic [NW-1:0]      mark_wr_node;
	logic               digit_ok;

	logic               fin;
	logic [NW-1:0]      fin_node;
	logic               fin_path;
	logic               fin_cons;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign consistent = cons_q;
	assign overflow   = ovf_q;

	// digit outside the radix makes no trie move
	assign digit_ok = ({1'b0, digit_s1} < (DIGIT_W + 1)'(RADIX));

	dtpc_store #(
		.NODES(NODES),
		.RADIX(RADIX)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rd_node     (cur_q),
		.digit       (digit_s1),
		.alloc_link  (free_q[NW-1:0]),
		.mark_rd_node(mark_rd_node),
		.mark_wr_node(mark_wr_node),
		.link        (link),
		.mark        (mark),
		.clearing    (clearing)
	);

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		free_d       = free_q;
		path_d       = path_q;
		cons_d       = cons_q;
		ovf_d        = ovf_q;
		done_d       = 1'b0;
		ctl          = '0;
		mark_rd_node = link;
		mark_wr_node = cur_q;
		fin          = 1'b0;
		fin_node     = cur_q;
		fin_path     = path_q;
		fin_cons     = cons_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action) begin
						// new set: drop all flags and sweep the store
						ctl.clear = 1'b1;
						state_d   = ST_CLEAR;
						cur_d     = '0;
						free_d    = FW'(1);
						path_d    = 1'b0;
						cons_d    = 1'b1;
						ovf_d     = 1'b0;
					end else begin
						// fetch the child row of the current node
						ctl.rd  = 1'b1;
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (!digit_ok) begin
					fin = 1'b1;
				end else if (link == '0) begin
					// missing child: allocate, or flag an empty pool and hold
					if (free_q < FW'(NODES)) begin
						ctl.alloc = 1'b1;
						fin_node  = free_q[NW-1:0];
						free_d    = free_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					fin_path = 1'b1;
					fin      = 1'b1;
				end else begin
					// follow the link; its end mark comes back next cycle
					cur_d       = link;
					ctl.mark_rd = 1'b1;
					state_d     = ST_MARK;
				end
			end
			ST_MARK: begin
				fin      = 1'b1;
				fin_cons = cons_q & ~mark;
			end
			ST_CLEAR: begin
				if (!clearing) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = ST_IDLE;
			if (last_s1) begin
				// end of string: mark the node, return to the root, report
				ctl.mark_wr  = 1'b1;
				mark_wr_node = fin_node;
				cons_d       = fin_cons & fin_path;
				cur_d        = '0;
				path_d       = 1'b0;
				done_d       = 1'b1;
			end else begin
				cur_d  = fin_node;
				path_d = fin_path;
				cons_d = fin_cons;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cur_q   <= '0;
			free_q  <= FW'(1);
			path_q  <= 1'b0;
			cons_q  <= 1'b1;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			free_q  <= free_d;
			path_q  <= path_d;
			cons_q  <= cons_d;
			ovf_q   <= ovf_d;
			done_q  <= done_d;
		end
	end

	// hold the digit beat for the look-up
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			digit_s1 <= digit;
			last_s1  <= last;
		end
	end

`ifndef SYNTHESIS
	a_sweep_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> state_q == ST_CLEAR)
		else $error("store sweep running outside the clear state");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q != '0 && free_q <= FW'(NODES))
		else $error("free count out of range");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> free_q < FW'(NODES))
		else $error("allocation from an empty pool");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE && cur_q == '0 && !path_q)
		else $error("result without return to the root");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action) |=> busy && !done_q && cons_q && !ovf_q)
		else $error("new set did not reset flags");
`endif

endmodule
